FILE: rtl/core/pagerank_pull_engine_defines.svh
// Assertion macros used by the pagerank pull engine datapath.
`ifndef PAGERANK_PULL_ENGINE_DEFINES_SVH
`define PAGERANK_PULL_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is held.
`define PRP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pagerank pull engine check failed");
// Clocked check that also holds during reset.
`define PRP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pagerank pull engine check failed");
`else
`define PRP_ASSERT(lbl, clk, rst_n, prop)
`define PRP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/prp_pkg.sv
// Types and constants of the pagerank pull engine.
package prp_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 13;
    localparam int NODE_FIELD_W = 10;

    localparam logic [DATA_W-1:0]  Q_085     = 32'd55706;
    localparam logic [DATA_W-1:0]  Q_015     = 32'd9830;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd1;
    localparam logic [1:0] CFG_MAX_ROUNDS = 2'd2;

    localparam logic [10:0] NODE_COUNT_RST = 11'd1024;
    localparam logic [15:0] TOLERANCE_RST  = 16'd655;
    localparam logic [7:0]  MAX_ROUNDS_RST = 8'd64;

    typedef enum logic [4:0] {
        S_RESET_CLR,
        S_IDLE,
        S_DECODE,
        S_LOAD_WR,
        S_READ_OUT,
        S_ERR_OUT,
        S_INIT,
        S_ROUND,
        S_EDGE_RD,
        S_EDGE_FETCH,
        S_EDGE_START,
        S_EDGE_DIV,
        S_EDGE_ACC,
        S_EDGE_NEXT,
        S_NODE_RD,
        S_NODE_MUL,
        S_NODE_UPD,
        S_SUM_CLR,
        S_ROUND_END,
        S_RUN_END
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_SWEEP_RESET,
        OP_DECODE,
        OP_LOAD_WR,
        OP_READ_OUT,
        OP_ERR_OUT,
        OP_SWEEP_INIT,
        OP_ROUND_START,
        OP_EDGE_RD,
        OP_EDGE_FETCH,
        OP_EDGE_START,
        OP_EDGE_WAIT,
        OP_EDGE_ACC,
        OP_EDGE_NEXT,
        OP_NODE_RD,
        OP_NODE_MUL,
        OP_NODE_UPD,
        OP_SWEEP_SUM,
        OP_ROUND_END,
        OP_RUN_END
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_take;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       dec_err;
        logic       out_free;
        logic       idx_last;
        logic       edge_last;
        logic       node_last;
        logic       edges_empty;
        logic       node_none;
        logic       cnt_zero;
        logic       div_done;
        logic       more_rounds;
    } t_status;

endpackage

FILE: rtl/core/prp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module prp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/prp_div.sv
// Restoring divider, one quotient bit per cycle, for rank over target count.
module prp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [prp_pkg::DATA_W-1:0]   i_dividend,
    input  logic [prp_pkg::COUNT_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [prp_pkg::DATA_W-1:0]   o_quotient
);
    import prp_pkg::*;

    localparam int SW = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [DATA_W-1:0] r_q;
    logic [COUNT_W-1:0] r_r;
    logic [COUNT_W-1:0] r_d;

    logic [COUNT_W:0] rem_sh;
    logic [COUNT_W:0] rem_nx;
    logic             ge;

    assign rem_sh = {r_r, r_q[DATA_W-1]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign rem_nx = ge ? rem_sh - {1'b0, r_d} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + SW'(1);
            if (r_step == SW'(DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DATA_W-2:0], ge};
            r_r <= rem_nx[COUNT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/core/prp_datapath.sv
// Datapath: configuration, edge and node memories, divider, multiplier and result word.
`include "pagerank_pull_engine_defines.svh"
module prp_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [1:0]                        i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    input  logic [1:0]                        i_mode,
    input  logic [prp_pkg::NODE_FIELD_W-1:0]  i_edge_source,
    input  logic [prp_pkg::NODE_FIELD_W-1:0]  i_edge_target,
    input  logic [prp_pkg::NODE_FIELD_W-1:0]  i_query_node,
    input  prp_pkg::t_cmd                     i_cmd,
    output prp_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [prp_pkg::DATA_W-1:0]        o_rank_value,
    output logic [7:0]                        o_rounds_done,
    output logic                              o_converged,
    output logic                              o_error
);
    import prp_pkg::*;

    localparam int NAW = $clog2(MAX_NODES);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ELW = $clog2(MAX_EDGES + 1);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int IW  = (ELW > NCW) ? ELW : NCW;

    // Configuration registers.
    logic [10:0] r_node_count;
    logic [15:0] r_tolerance;
    logic [7:0]  r_max_rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_tolerance  <= TOLERANCE_RST;
            r_max_rounds <= MAX_ROUNDS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[10:0];
                CFG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                CFG_MAX_ROUNDS: r_max_rounds <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Latched input word.
    logic [1:0]              r_mode;
    logic [NODE_FIELD_W-1:0] r_src;
    logic [NODE_FIELD_W-1:0] r_tgt;
    logic [NODE_FIELD_W-1:0] r_qn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_mode <= i_mode;
            r_src  <= i_edge_source;
            r_tgt  <= i_edge_target;
            r_qn   <= i_query_node;
        end
    end

    logic [NCW-1:0] n_eff;
    logic [7:0]     cap;
    logic           dec_err;

    assign n_eff = (32'(r_node_count) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(r_node_count);
    assign cap   = (r_max_rounds == 8'd0) ? 8'd1 : r_max_rounds;

    logic [ELW-1:0]    r_edges_loaded;
    logic [IW-1:0]     r_idx;
    logic [NAW-1:0]    r_es;
    logic [DATA_W-1:0] r_sum;
    logic [47:0]       r_prod;
    logic [DATA_W-1:0] r_old;
    logic [NCW-1:0]    r_change;
    logic [7:0]        r_rounds;
    logic [7:0]        r_last_rounds;
    logic              r_last_conv;

    always_comb begin
        unique case (r_mode)
            MODE_LOAD: dec_err = (32'(r_edges_loaded) >= 32'(MAX_EDGES))
                                 || (32'(r_src) >= 32'(n_eff))
                                 || (32'(r_tgt) >= 32'(n_eff));
            MODE_RUN:  dec_err = 1'b0;
            MODE_READ: dec_err = 32'(r_qn) >= 32'(n_eff);
            default:   dec_err = 1'b1;
        endcase
    end

    // Edge table.
    logic               e_we;
    logic [2*NAW-1:0]   e_rd;
    logic [NAW-1:0]     e_src;
    logic [NAW-1:0]     e_tgt;

    assign e_we  = (i_cmd.op == OP_DECODE) && (r_mode == MODE_LOAD) && !dec_err;
    assign e_src = e_rd[2*NAW-1:NAW];
    assign e_tgt = e_rd[NAW-1:0];

    prp_ram #(.WIDTH(2 * NAW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (EAW'(r_edges_loaded)),
        .i_wdata ({NAW'(r_src), NAW'(r_tgt)}),
        .i_raddr (EAW'(r_idx)),
        .o_rdata (e_rd)
    );

    // Node memories: target counts, ranks and pull sums.
    logic               c_we;
    logic [NAW-1:0]     c_waddr;
    logic [COUNT_W-1:0] c_wdata;
    logic [NAW-1:0]     c_raddr;
    logic [COUNT_W-1:0] c_rd;

    logic               k_we;
    logic [NAW-1:0]     k_waddr;
    logic [DATA_W-1:0]  k_wdata;
    logic [NAW-1:0]     k_raddr;
    logic [DATA_W-1:0]  k_rd;

    logic               s_we;
    logic [NAW-1:0]     s_waddr;
    logic [DATA_W-1:0]  s_wdata;
    logic [NAW-1:0]     s_raddr;
    logic [DATA_W-1:0]  s_rd;

    logic              div_busy;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    logic [DATA_W:0]   acc_sum;
    logic [DATA_W-1:0] acc_sat;
    logic [DATA_W-1:0] scaled;
    logic [DATA_W:0]   cand_sum;
    logic [DATA_W-1:0] cand;
    logic [DATA_W-1:0] diff;
    logic              upd;

    assign acc_sum  = {1'b0, r_sum} + {1'b0, div_q};
    assign acc_sat  = acc_sum[DATA_W] ? '1 : acc_sum[DATA_W-1:0];
    assign scaled   = r_prod[47:16];
    assign cand_sum = {1'b0, scaled} + {1'b0, Q_015};
    assign cand     = cand_sum[DATA_W] ? '1 : cand_sum[DATA_W-1:0];
    assign diff     = (cand > r_old) ? cand - r_old : r_old - cand;
    assign upd      = diff > 32'(r_tolerance);

    always_comb begin
        c_we    = 1'b0;
        c_waddr = NAW'(r_idx);
        c_wdata = '0;
        if (i_cmd.op == OP_SWEEP_RESET) begin
            c_we = 1'b1;
        end else if (i_cmd.op == OP_LOAD_WR) begin
            c_we    = 1'b1;
            c_waddr = NAW'(r_tgt);
            c_wdata = (c_rd < COUNT_MAX) ? c_rd + COUNT_W'(1) : c_rd;
        end
        c_raddr = (i_cmd.op == OP_DECODE) ? NAW'(r_tgt) : e_tgt;
    end

    always_comb begin
        k_we    = 1'b0;
        k_waddr = NAW'(r_idx);
        k_wdata = Q_085;
        if (i_cmd.op == OP_SWEEP_RESET || i_cmd.op == OP_SWEEP_INIT) begin
            k_we = 1'b1;
        end else if (i_cmd.op == OP_NODE_UPD && upd) begin
            k_we    = 1'b1;
            k_wdata = cand;
        end
        if (i_cmd.op == OP_DECODE) begin
            k_raddr = NAW'(r_qn);
        end else if (i_cmd.op == OP_EDGE_FETCH) begin
            k_raddr = e_tgt;
        end else begin
            k_raddr = NAW'(r_idx);
        end
    end

    always_comb begin
        s_we    = 1'b0;
        s_waddr = NAW'(r_idx);
        s_wdata = '0;
        if (i_cmd.op == OP_SWEEP_RESET || i_cmd.op == OP_SWEEP_INIT
            || i_cmd.op == OP_SWEEP_SUM) begin
            s_we = 1'b1;
        end else if (i_cmd.op == OP_EDGE_ACC) begin
            s_we    = 1'b1;
            s_waddr = r_es;
            s_wdata = acc_sat;
        end
        s_raddr = (i_cmd.op == OP_EDGE_FETCH) ? e_src : NAW'(r_idx);
    end

    prp_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rd)
    );

    prp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (k_raddr),
        .o_rdata (k_rd)
    );

    prp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rd)
    );

    prp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (k_rd),
        .i_divisor  (c_rd),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    logic idx_last;
    logic edge_last;
    logic node_last;

    assign idx_last  = r_idx == IW'(MAX_NODES - 1);
    assign edge_last = r_idx == (IW'(r_edges_loaded) - IW'(1));
    assign node_last = r_idx == (IW'(n_eff) - IW'(1));

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges_loaded <= '0;
            r_idx          <= '0;
            r_change       <= '0;
            r_rounds       <= '0;
            r_last_rounds  <= '0;
            r_last_conv    <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_SWEEP_RESET, OP_SWEEP_SUM: begin
                    r_idx <= idx_last ? '0 : r_idx + IW'(1);
                end
                OP_SWEEP_INIT: begin
                    r_idx    <= idx_last ? '0 : r_idx + IW'(1);
                    r_rounds <= '0;
                end
                OP_LOAD_WR: r_edges_loaded <= r_edges_loaded + ELW'(1);
                OP_ROUND_START: begin
                    r_idx    <= '0;
                    r_change <= '0;
                end
                OP_EDGE_NEXT: r_idx <= edge_last ? '0 : r_idx + IW'(1);
                OP_NODE_UPD: begin
                    r_idx <= node_last ? '0 : r_idx + IW'(1);
                    if (upd) begin
                        r_change <= r_change + NCW'(1);
                    end
                end
                OP_ROUND_END: r_rounds <= r_rounds + 8'd1;
                OP_RUN_END: begin
                    r_last_rounds <= r_rounds;
                    r_last_conv   <= r_change == '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EDGE_FETCH) begin
            r_es <= e_src;
        end
        if (i_cmd.op == OP_EDGE_START) begin
            r_sum <= s_rd;
        end
        if (i_cmd.op == OP_NODE_MUL) begin
            r_prod <= 48'(s_rd) * 48'(Q_085);
            r_old  <= k_rd;
        end
    end

    // Result word register.
    logic out_wr;
    logic r_out_valid;
    logic [DATA_W-1:0] r_rank_value;
    logic [7:0]        r_rounds_done;
    logic              r_converged;
    logic              r_error;

    assign out_wr = (i_cmd.op == OP_LOAD_WR) || (i_cmd.op == OP_READ_OUT)
                    || (i_cmd.op == OP_ERR_OUT) || (i_cmd.op == OP_RUN_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_wr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_rank_value  <= (i_cmd.op == OP_READ_OUT) ? k_rd : '0;
            r_error       <= i_cmd.op == OP_ERR_OUT;
            r_rounds_done <= (i_cmd.op == OP_RUN_END) ? r_rounds : r_last_rounds;
            r_converged   <= (i_cmd.op == OP_RUN_END) ? (r_change == '0) : r_last_conv;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rank_value  = r_rank_value;
    assign o_rounds_done = r_rounds_done;
    assign o_converged   = r_converged;
    assign o_error       = r_error;

    always_comb begin
        o_status.mode        = r_mode;
        o_status.dec_err     = dec_err;
        o_status.out_free    = !r_out_valid || !i_out_stall;
        o_status.idx_last    = idx_last;
        o_status.edge_last   = edge_last;
        o_status.node_last   = node_last;
        o_status.edges_empty = r_edges_loaded == '0;
        o_status.node_none   = n_eff == '0;
        o_status.cnt_zero    = c_rd == '0;
        o_status.div_done    = div_done;
        o_status.more_rounds = (r_change != '0) && ((9'(r_rounds) + 9'd1) < 9'(cap));
    end

    // A result word must never overwrite one that is still waiting.
    `PRP_ASSERT(a_out_no_overwrite, i_clk, i_rst_n, out_wr |-> (!r_out_valid || !i_out_stall))
    `PRP_ASSERT(a_div_idle_start, i_clk, i_rst_n, i_cmd.div_start |-> !div_busy)
    `PRP_ASSERT(a_load_counts, i_clk, i_rst_n,
        (i_cmd.op == OP_LOAD_WR) |=> (r_edges_loaded == $past(r_edges_loaded) + ELW'(1)))

endmodule

FILE: rtl/core/prp_ctrl.sv
// Controller state machine sequencing loads, reads and ranking rounds.
module prp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  prp_pkg::t_status i_status,
    output prp_pkg::t_cmd    o_cmd
);
    import prp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RESET_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RESET_CLR: if (i_status.idx_last) n_state = S_IDLE;
            S_IDLE:      if (i_in_valid && i_status.out_free) n_state = S_DECODE;
            S_DECODE: begin
                if (i_status.dec_err) begin
                    n_state = S_ERR_OUT;
                end else begin
                    unique case (i_status.mode)
                        MODE_LOAD: n_state = S_LOAD_WR;
                        MODE_RUN:  n_state = S_INIT;
                        MODE_READ: n_state = S_READ_OUT;
                        default:   n_state = S_ERR_OUT;
                    endcase
                end
            end
            S_LOAD_WR, S_READ_OUT, S_ERR_OUT, S_RUN_END: n_state = S_IDLE;
            S_INIT: if (i_status.idx_last) n_state = S_ROUND;
            S_ROUND: begin
                priority if (!i_status.edges_empty) n_state = S_EDGE_RD;
                else if (!i_status.node_none)       n_state = S_NODE_RD;
                else                                n_state = S_SUM_CLR;
            end
            S_EDGE_RD:    n_state = S_EDGE_FETCH;
            S_EDGE_FETCH: n_state = S_EDGE_START;
            S_EDGE_START: n_state = i_status.cnt_zero ? S_EDGE_NEXT : S_EDGE_DIV;
            S_EDGE_DIV:   if (i_status.div_done) n_state = S_EDGE_ACC;
            S_EDGE_ACC:   n_state = S_EDGE_NEXT;
            S_EDGE_NEXT: begin
                priority if (!i_status.edge_last) n_state = S_EDGE_RD;
                else if (!i_status.node_none)     n_state = S_NODE_RD;
                else                              n_state = S_SUM_CLR;
            end
            S_NODE_RD:   n_state = S_NODE_MUL;
            S_NODE_MUL:  n_state = S_NODE_UPD;
            S_NODE_UPD:  n_state = i_status.node_last ? S_SUM_CLR : S_NODE_RD;
            S_SUM_CLR:   if (i_status.idx_last) n_state = S_ROUND_END;
            S_ROUND_END: n_state = i_status.more_rounds ? S_ROUND : S_RUN_END;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.in_take   = (r_state == S_IDLE) && i_in_valid && i_status.out_free;
        o_cmd.div_start = (r_state == S_EDGE_START) && !i_status.cnt_zero;
        o_in_stall      = !((r_state == S_IDLE) && i_status.out_free);
        unique case (r_state)
            S_RESET_CLR:  o_cmd.op = OP_SWEEP_RESET;
            S_IDLE:       o_cmd.op = OP_IDLE;
            S_DECODE:     o_cmd.op = OP_DECODE;
            S_LOAD_WR:    o_cmd.op = OP_LOAD_WR;
            S_READ_OUT:   o_cmd.op = OP_READ_OUT;
            S_ERR_OUT:    o_cmd.op = OP_ERR_OUT;
            S_INIT:       o_cmd.op = OP_SWEEP_INIT;
            S_ROUND:      o_cmd.op = OP_ROUND_START;
            S_EDGE_RD:    o_cmd.op = OP_EDGE_RD;
            S_EDGE_FETCH: o_cmd.op = OP_EDGE_FETCH;
            S_EDGE_START: o_cmd.op = OP_EDGE_START;
            S_EDGE_DIV:   o_cmd.op = OP_EDGE_WAIT;
            S_EDGE_ACC:   o_cmd.op = OP_EDGE_ACC;
            S_EDGE_NEXT:  o_cmd.op = OP_EDGE_NEXT;
            S_NODE_RD:    o_cmd.op = OP_NODE_RD;
            S_NODE_MUL:   o_cmd.op = OP_NODE_MUL;
            S_NODE_UPD:   o_cmd.op = OP_NODE_UPD;
            S_SUM_CLR:    o_cmd.op = OP_SWEEP_SUM;
            S_ROUND_END:  o_cmd.op = OP_ROUND_END;
            S_RUN_END:    o_cmd.op = OP_RUN_END;
            default:      o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/pagerank_pull_engine.sv
// Top level of the pull-style fixed-point pagerank engine.
//
//  channel  direction  handshake                 word
//  in       input      i_in_valid / o_in_stall   mode, edge source, edge target, query node
//  out      output     o_out_valid / i_out_stall rank, rounds done, converged, error
//  cfg      input      i_cfg_valid / o_cfg_ready register index, write data
//
// After reset a clearing pass over MAX_NODES entries initializes counts, ranks and sums;
// no word is accepted until it ends. A load, read or rejected word is decoded while the
// count and rank memories are read, and its result word is registered in the state after
// decode. A run first initializes all MAX_NODES ranks, then in each round visits every
// loaded edge (fetch, bit-serial divide when the target count is nonzero, accumulate),
// updates each active node and clears the sums. One word is in flight at a time; a waiting
// result stalls the next accept only when o_out_valid is held by i_out_stall.
module pagerank_pull_engine #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [prp_pkg::NODE_FIELD_W-1:0]  i_edge_source,
    input  logic [prp_pkg::NODE_FIELD_W-1:0]  i_edge_target,
    input  logic [prp_pkg::NODE_FIELD_W-1:0]  i_query_node,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [prp_pkg::DATA_W-1:0]        o_rank_value,
    output logic [7:0]                        o_rounds_done,
    output logic                              o_converged,
    output logic                              o_error
);
    import prp_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    prp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    prp_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_edge_source (i_edge_source),
        .i_edge_target (i_edge_target),
        .i_query_node  (i_query_node),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rank_value  (o_rank_value),
        .o_rounds_done (o_rounds_done),
        .o_converged   (o_converged),
        .o_error       (o_error)
    );

endmodule
